// ===== rtl/gcd_pkg.sv =====
// Shared types, step addresses and the control store for the GCD block.
// Used by gcd_seq and greatest_common_divisor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned PC_BITS        = 4;

  typedef logic [PC_BITS-1:0] pc_t;

  // step addresses of the control program
  localparam pc_t STEP_IDLE   = 4'd0;
  localparam pc_t STEP_A_ZERO = 4'd1;
  localparam pc_t STEP_B_ZERO = 4'd2;
  localparam pc_t STEP_TWOS   = 4'd3;
  localparam pc_t STEP_NORM_A = 4'd4;
  localparam pc_t STEP_NORM_B = 4'd5;
  localparam pc_t STEP_SUB    = 4'd6;
  localparam pc_t STEP_TAKE_B = 4'd7;
  localparam pc_t STEP_EMIT   = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_HALVE_AB = 3'd2,
    OP_HALVE_A  = 3'd3,
    OP_HALVE_B  = 3'd4,
    OP_SUB      = 3'd5,
    OP_TAKE_B   = 3'd6,
    OP_EMIT     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER         = 3'd0,
    CND_NO_START      = 3'd1,
    CND_A_ZERO        = 3'd2,
    CND_B_ZERO        = 3'd3,
    CND_ANY_ODD       = 3'd4,
    CND_A_ODD         = 3'd5,
    CND_B_ODD_OR_ZERO = 3'd6
  } cond_t;

  // when cond holds: jump to target, no operation; otherwise run op, go to next
  typedef struct packed {
    cond_t cond;
    pc_t   target;
    op_t   op;
    pc_t   next;
  } uword_t;

  typedef struct packed {
    logic start;
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
  } flags_t;

  typedef struct packed {
    op_t  op;
    logic busy;
  } ctrl_t;

  function automatic uword_t ucode_rom(input pc_t addr);
    uword_t w;
    case (addr)
      STEP_IDLE:   w = '{CND_NO_START,      STEP_IDLE,   OP_LOAD,     STEP_A_ZERO};
      STEP_A_ZERO: w = '{CND_A_ZERO,        STEP_TAKE_B, OP_NOP,      STEP_B_ZERO};
      STEP_B_ZERO: w = '{CND_B_ZERO,        STEP_EMIT,   OP_NOP,      STEP_TWOS};
      STEP_TWOS:   w = '{CND_ANY_ODD,       STEP_NORM_A, OP_HALVE_AB, STEP_TWOS};
      STEP_NORM_A: w = '{CND_A_ODD,         STEP_NORM_B, OP_HALVE_A,  STEP_NORM_A};
      STEP_NORM_B: w = '{CND_B_ODD_OR_ZERO, STEP_SUB,    OP_HALVE_B,  STEP_NORM_B};
      STEP_SUB:    w = '{CND_B_ZERO,        STEP_EMIT,   OP_SUB,      STEP_NORM_B};
      STEP_TAKE_B: w = '{CND_NEVER,         STEP_IDLE,   OP_TAKE_B,   STEP_EMIT};
      STEP_EMIT:   w = '{CND_NEVER,         STEP_IDLE,   OP_EMIT,     STEP_IDLE};
      default:     w = '{CND_NEVER,         STEP_IDLE,   OP_NOP,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gcd_seq.sv =====
// Microcode sequencer for the GCD block: step counter, control store lookup
// and jump evaluation. Depends on gcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcd_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  gcd_pkg::flags_t      flags,
  output gcd_pkg::ctrl_t       ctrl
);

  gcd_pkg::pc_t    pc_r;
  gcd_pkg::pc_t    pc_nxt;
  gcd_pkg::uword_t word;
  logic            taken;

  always_comb begin
    word = gcd_pkg::ucode_rom(pc_r);
    case (word.cond)
      gcd_pkg::CND_NEVER:         taken = 1'b0;
      gcd_pkg::CND_NO_START:      taken = !flags.start;
      gcd_pkg::CND_A_ZERO:        taken = flags.a_zero;
      gcd_pkg::CND_B_ZERO:        taken = flags.b_zero;
      gcd_pkg::CND_ANY_ODD:       taken = flags.a_odd | flags.b_odd;
      gcd_pkg::CND_A_ODD:         taken = flags.a_odd;
      gcd_pkg::CND_B_ODD_OR_ZERO: taken = flags.b_odd | flags.b_zero;
      default:                    taken = 1'b0;
    endcase
    pc_nxt    = taken ? word.target : word.next;
    ctrl.op   = taken ? gcd_pkg::OP_NOP : word.op;
    ctrl.busy = (pc_r != gcd_pkg::STEP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= gcd_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/greatest_common_divisor.sv =====
// Greatest common divisor top level: operand datapath driven by gcd_seq.
// Depends on gcd_pkg and gcd_seq.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: drive in_first_value and in_second_value with start high; the
//   word is taken at a rising edge where start is high and busy is low.
//   busy stays high while the pair is being worked on.
//   Output: out_divisor_result is valid for exactly one cycle, marked by
//   out_valid. The receiver cannot stall; the result must be taken then.
//   gcd(x, 0) = gcd(0, x) = x and gcd(0, 0) = 0.
// Timing
//   Binary (Stein) GCD run by a microcoded sequencer, one control step per
//   cycle. The time from accept to out_valid depends on the operands: a
//   zero operand takes the shortest path, and otherwise it grows with the
//   halving and subtract steps, since every subtract is followed by a test
//   of b. The subtract/halve loop on the operand registers sets this time.
//   A new word may be accepted in the cycle out_valid is high, so one item
//   is in flight at a time.
// Reset
//   rst_n (synchronous, active low) returns the sequencer to idle and
//   clears out_valid; no clearing pass is needed.
module greatest_common_divisor #(
  parameter int unsigned VALUE_BITS = gcd_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [VALUE_BITS-1:0] in_first_value,
  input  wire logic [VALUE_BITS-1:0] in_second_value,
  output      logic                  out_valid,
  output      logic [VALUE_BITS-1:0] out_divisor_result
);

  localparam int unsigned K_BITS = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;
  logic [K_BITS-1:0]     k_r;
  logic [VALUE_BITS-1:0] result_r;
  logic                  valid_r;
  logic [VALUE_BITS:0]   diff;
  gcd_pkg::flags_t       flags;
  gcd_pkg::ctrl_t        ctrl;

  assign flags = '{
    start:  start,
    a_zero: (a_r == '0),
    b_zero: (b_r == '0),
    a_odd:  a_r[0],
    b_odd:  b_r[0]
  };

  gcd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // borrow out of b - a means a > b
  assign diff = {1'b0, b_r} - {1'b0, a_r};

  always_ff @(posedge clk) begin
    case (ctrl.op)
      gcd_pkg::OP_LOAD: begin
        a_r <= in_first_value;
        b_r <= in_second_value;
        k_r <= '0;
      end
      gcd_pkg::OP_HALVE_AB: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + K_BITS'(1);
      end
      gcd_pkg::OP_HALVE_A: begin
        a_r <= a_r >> 1;
      end
      gcd_pkg::OP_HALVE_B: begin
        b_r <= b_r >> 1;
      end
      gcd_pkg::OP_SUB: begin
        // keep the smaller in a, the difference in b
        if (diff[VALUE_BITS]) begin
          a_r <= b_r;
          b_r <= a_r - b_r;
        end else begin
          b_r <= diff[VALUE_BITS-1:0];
        end
      end
      gcd_pkg::OP_TAKE_B: begin
        a_r <= b_r;
      end
      gcd_pkg::OP_EMIT: begin
        result_r <= a_r << k_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.op == gcd_pkg::OP_EMIT);
    end
  end

  assign busy               = ctrl.busy;
  assign out_valid          = valid_r;
  assign out_divisor_result = result_r;

endmodule

`default_nettype wire
